[design/bmm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the banked memory mapper: access opcodes,
// device codes, layout bit positions and memory geometry.
// ---------------------------------------------------------------------------
package bmm_pkg;

    // memory geometry
    localparam int ADDR_WIDTH = 16;
    localparam int MEM_DEPTH  = 1 << ADDR_WIDTH;

    // access opcodes
    localparam logic [2:0] OP_CPU_READ  = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE = 3'd1;
    localparam logic [2:0] OP_RAW_READ  = 3'd2;
    localparam logic [2:0] OP_RAW_WRITE = 3'd3;
    localparam logic [2:0] OP_VID_READ  = 3'd4;
    localparam logic [2:0] OP_ROM_LOAD  = 3'd5;

    // device select codes
    localparam logic [1:0] DEV_NONE  = 2'd0;
    localparam logic [1:0] DEV_VIDEO = 2'd1;
    localparam logic [1:0] DEV_IO1   = 2'd2;
    localparam logic [1:0] DEV_IO2   = 2'd3;

    // layout register bit positions
    localparam int BIT_LORAM  = 0;
    localparam int BIT_HIRAM  = 1;
    localparam int BIT_CHAREN = 2;

    localparam logic [2:0]            LAYOUT_RESET = 3'd7;
    localparam logic [ADDR_WIDTH-1:0] LAYOUT_ADDR  = 16'h0001;
    localparam logic [ADDR_WIDTH-1:0] PORT_DIR_ADDR = 16'h0000;
    localparam logic [7:0]            PORT_DIR_INIT = 8'h2f;
    localparam logic [7:0]            LAYOUT_INIT   = 8'h07;
    localparam logic [3:0]            CHAR_ROM_HI   = 4'hd;

    // where the read byte of a transaction comes from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RAM,
        SRC_ROM
    } t_src;

    // decoded transaction carried to the output side
    typedef struct packed {
        t_src       src;
        logic [1:0] dsel;
        logic [6:0] dreg;
        logic       dwr;
    } t_result_ctl;

endpackage

[design/banked_memory_mapper_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// banked_memory_mapper_unit
// Memory mapper for a 64K byte machine: routes CPU, raw, video and ROM-load
// transactions to RAM, ROM or device registers under three layout bits.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 65536 addresses of
// RAM and ROM (RAM bytes 0 and 1 are preset to 0x2f and 0x07) and holds
// o_stall high throughout. Then it takes one transaction per cycle while
// the receiver does not stall. The RAM/ROM array read register loads at
// the accepting edge and the result register when stage one advances, so
// a result passes the array read register, then the result register. While
// the result register holds a result that the receiver stalls, o_stall
// follows i_stall, so at most two transactions are in flight. Each array
// has a single port, used at most once per transaction. A CPU write to
// address 0x0001 updates the layout bits for the very next transaction.
module banked_memory_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [1:0]  i_video_bank,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_device_select,
    output logic [6:0]  o_device_register,
    output logic        o_device_write
);

    localparam int AW = bmm_pkg::ADDR_WIDTH;

    logic [2:0]    r_layout;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic                 r_s1_valid;
    bmm_pkg::t_result_ctl r_s1_ctl;

    logic                 r_out_valid;
    logic [7:0]           r_out_rd;
    bmm_pkg::t_result_ctl r_out_ctl;

    logic s1_advance;
    logic accept;

    // decoded transaction
    logic                 dec_ram_we;
    logic                 dec_ram_re;
    logic [AW-1:0]        dec_ram_addr;
    logic                 dec_rom_we;
    logic                 dec_rom_re;
    logic [AW-1:0]        dec_rom_addr;
    logic                 dec_layout_we;
    bmm_pkg::t_result_ctl dec_ctl;

    // address classification
    logic          lo, hi, ch;
    logic          area_io, area_ramc;
    logic          in_vid_pages, in_cia_pages, in_basic, in_kernal;
    logic [AW-1:0] vid_addr;
    logic          in_char_win;
    logic [1:0]    cia_sel;

    // memory ports
    logic          ram_we, ram_re, rom_we, rom_re;
    logic [AW-1:0] ram_addr, rom_addr;
    logic [7:0]    ram_wdata, rom_wdata, ram_rdata, rom_rdata;

    logic [2:0] n_layout;
    logic [7:0] n_out_rd;

    // handshake
    assign s1_advance = !r_out_valid || !i_stall;
    assign o_stall    = r_clr_busy || !s1_advance;
    assign accept     = i_valid && !o_stall;

    // layout modes and address windows
    assign lo           = r_layout[bmm_pkg::BIT_LORAM];
    assign hi           = r_layout[bmm_pkg::BIT_HIRAM];
    assign ch           = r_layout[bmm_pkg::BIT_CHAREN];
    assign area_io      = ch && (lo || hi);
    assign area_ramc    = ch && !lo && !hi;
    assign in_vid_pages = (i_address[15:10] == 6'b110100);
    assign in_cia_pages = (i_address[15:9] == 7'b1101110);
    assign cia_sel      = i_address[8] ? bmm_pkg::DEV_IO2 : bmm_pkg::DEV_IO1;
    assign in_basic     = (i_address[15:13] == 3'b101);
    assign in_kernal    = (i_address[15:13] == 3'b111);
    assign vid_addr     = {i_video_bank, i_address[13:0]};
    assign in_char_win  = (vid_addr[14:12] == 3'b001);

    // transaction decode
    always_comb begin
        dec_ram_we    = 1'b0;
        dec_ram_re    = 1'b0;
        dec_ram_addr  = i_address;
        dec_rom_we    = 1'b0;
        dec_rom_re    = 1'b0;
        dec_rom_addr  = i_address;
        dec_layout_we = 1'b0;
        dec_ctl.src   = bmm_pkg::SRC_NONE;
        dec_ctl.dsel  = bmm_pkg::DEV_NONE;
        dec_ctl.dreg  = 7'd0;
        dec_ctl.dwr   = 1'b0;
        unique case (i_op)
            bmm_pkg::OP_CPU_READ: begin
                priority if (in_vid_pages) begin
                    priority if (area_io) begin
                        dec_ctl.dsel = bmm_pkg::DEV_VIDEO;
                        dec_ctl.dreg = i_address[6:0];
                    end else if (area_ramc) begin
                        dec_ram_re  = 1'b1;
                        dec_ctl.src = bmm_pkg::SRC_RAM;
                    end else begin
                        dec_rom_re  = 1'b1;
                        dec_ctl.src = bmm_pkg::SRC_ROM;
                    end
                end else if (in_cia_pages && area_io) begin
                    dec_ctl.dsel = cia_sel;
                    dec_ctl.dreg = {3'd0, i_address[3:0]};
                end else if ((in_basic && lo && hi) || (in_kernal && hi)) begin
                    dec_rom_re  = 1'b1;
                    dec_ctl.src = bmm_pkg::SRC_ROM;
                end else begin
                    dec_ram_re  = 1'b1;
                    dec_ctl.src = bmm_pkg::SRC_RAM;
                end
            end
            bmm_pkg::OP_CPU_WRITE: begin
                priority if (i_address == bmm_pkg::LAYOUT_ADDR) begin
                    dec_layout_we = 1'b1;
                    dec_ram_we    = 1'b1;
                end else if (in_vid_pages && area_io) begin
                    dec_ctl.dsel = bmm_pkg::DEV_VIDEO;
                    dec_ctl.dreg = i_address[6:0];
                    dec_ctl.dwr  = 1'b1;
                end else if (in_cia_pages && area_io) begin
                    dec_ctl.dsel = cia_sel;
                    dec_ctl.dreg = {3'd0, i_address[3:0]};
                    dec_ctl.dwr  = 1'b1;
                end else begin
                    dec_ram_we = 1'b1;
                end
            end
            bmm_pkg::OP_RAW_READ: begin
                dec_ram_re  = 1'b1;
                dec_ctl.src = bmm_pkg::SRC_RAM;
            end
            bmm_pkg::OP_RAW_WRITE: begin
                dec_ram_we = 1'b1;
            end
            bmm_pkg::OP_VID_READ: begin
                if (in_char_win) begin
                    dec_rom_re   = 1'b1;
                    dec_rom_addr = {bmm_pkg::CHAR_ROM_HI, vid_addr[11:0]};
                    dec_ctl.src  = bmm_pkg::SRC_ROM;
                end else begin
                    dec_ram_re   = 1'b1;
                    dec_ram_addr = vid_addr;
                    dec_ctl.src  = bmm_pkg::SRC_RAM;
                end
            end
            bmm_pkg::OP_ROM_LOAD: begin
                dec_rom_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // memory port muxing: clearing pass first, then accepted transactions
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_re    = 1'b0;
            ram_addr  = r_clr_addr;
            rom_we    = 1'b1;
            rom_re    = 1'b0;
            rom_addr  = r_clr_addr;
            rom_wdata = 8'd0;
            priority if (r_clr_addr == bmm_pkg::PORT_DIR_ADDR) begin
                ram_wdata = bmm_pkg::PORT_DIR_INIT;
            end else if (r_clr_addr == bmm_pkg::LAYOUT_ADDR) begin
                ram_wdata = bmm_pkg::LAYOUT_INIT;
            end else begin
                ram_wdata = 8'd0;
            end
        end else begin
            ram_we    = accept && dec_ram_we;
            ram_re    = accept && dec_ram_re;
            ram_addr  = dec_ram_addr;
            ram_wdata = i_data;
            rom_we    = accept && dec_rom_we;
            rom_re    = accept && dec_rom_re;
            rom_addr  = dec_rom_addr;
            rom_wdata = i_data;
        end
    end

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (bmm_pkg::MEM_DEPTH)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bmm_ram #(
        .WIDTH (8),
        .DEPTH (bmm_pkg::MEM_DEPTH)
    ) u_rom_image (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_re    (rom_re),
        .i_addr  (rom_addr),
        .i_wdata (rom_wdata),
        .o_rdata (rom_rdata)
    );

    // next layout and result byte
    always_comb begin
        n_layout = r_layout;
        if (accept && dec_layout_we) begin
            n_layout = i_data[2:0];
        end
        unique case (r_s1_ctl.src)
            bmm_pkg::SRC_RAM: n_out_rd = ram_rdata;
            bmm_pkg::SRC_ROM: n_out_rd = rom_rdata;
            default:          n_out_rd = 8'd0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout    <= bmm_pkg::LAYOUT_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_layout <= n_layout;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_advance) begin
                r_s1_valid  <= accept;
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= dec_ctl;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_rd  <= n_out_rd;
            r_out_ctl <= r_s1_ctl;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_out_rd;
    assign o_device_select   = r_out_ctl.dsel;
    assign o_device_register = r_out_ctl.dreg;
    assign o_device_write    = r_out_ctl.dwr;

endmodule

[design/bmm_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmm_ram
// Generic single-port RAM with registered read data; the read register
// only loads when a read is enabled.
// ---------------------------------------------------------------------------
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[test/bmm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmm_checker
// Watches both channels of the banked memory mapper, keeps its own image of
// RAM, ROM and the layout bits, predicts the result of every accepted
// transaction and compares each returned result against the oldest one.
// ---------------------------------------------------------------------------
module bmm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [1:0]  i_video_bank,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic [1:0]  i_device_select,
    input  logic [6:0]  i_device_register,
    input  logic        i_device_write,
    output int          o_mismatches,
    output int          o_pending
);

    // one result as it leaves the block
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] dev_sel;
        logic [6:0] dev_reg;
        logic       dev_wr;
    } t_bus_result;

    // what the D000-D3FF area shows under the current layout
    typedef enum logic [1:0] {
        CHR_AREA_RAM,
        CHR_AREA_ROM,
        CHR_AREA_IO
    } t_chr_area;

    localparam logic [7:0] PAGE_VIDEO_FIRST  = 8'hd0;
    localparam logic [7:0] PAGE_VIDEO_LAST   = 8'hd3;
    localparam logic [7:0] PAGE_IO1          = 8'hdc;
    localparam logic [7:0] PAGE_IO2          = 8'hdd;
    localparam logic [7:0] PAGE_BASIC_FIRST  = 8'ha0;
    localparam logic [7:0] PAGE_BASIC_LAST   = 8'hbf;
    localparam logic [7:0] PAGE_KERNAL_FIRST = 8'he0;
    localparam logic [3:0] CHR_WINDOW_LOW    = 4'h1;
    localparam logic [3:0] CHR_WINDOW_HIGH   = 4'h9;
    localparam int         MAX_REPORTS       = 10;

    logic [7:0]  ram_img [0:bmm_pkg::MEM_DEPTH-1];
    logic [7:0]  rom_img [0:bmm_pkg::MEM_DEPTH-1];
    logic [2:0]  layout;
    t_bus_result expected_q [$];
    int          mismatch_cnt = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // computes the result of one access and applies its side effects
    function automatic t_bus_result map_access(input logic [2:0] op, input logic [15:0] addr,
                                               input logic [7:0] data, input logic [1:0] bank);
        t_bus_result res;
        t_chr_area   area;
        logic [7:0]  page;
        logic [15:0] va;
        logic        lo;
        logic        hi;
        logic        ch;
        logic        video_page;
        logic        io_page;

        res  = '0;
        page = addr[15:8];
        lo   = layout[bmm_pkg::BIT_LORAM];
        hi   = layout[bmm_pkg::BIT_HIRAM];
        ch   = layout[bmm_pkg::BIT_CHAREN];
        if (ch && (lo || hi))
            area = CHR_AREA_IO;
        else if (ch)
            area = CHR_AREA_RAM;
        else
            area = CHR_AREA_ROM;
        video_page = (page >= PAGE_VIDEO_FIRST) && (page <= PAGE_VIDEO_LAST);
        io_page    = (page == PAGE_IO1) || (page == PAGE_IO2);

        case (op)
            bmm_pkg::OP_CPU_READ: begin
                if (video_page) begin
                    if (area == CHR_AREA_IO) begin
                        res.dev_sel = bmm_pkg::DEV_VIDEO;
                        res.dev_reg = addr[6:0];
                    end else if (area == CHR_AREA_ROM) begin
                        res.read_data = rom_img[addr];
                    end else begin
                        res.read_data = ram_img[addr];
                    end
                end else if (io_page) begin
                    if (area == CHR_AREA_IO) begin
                        res.dev_sel = (page == PAGE_IO1) ? bmm_pkg::DEV_IO1 : bmm_pkg::DEV_IO2;
                        res.dev_reg = {3'b000, addr[3:0]};
                    end else begin
                        res.read_data = ram_img[addr];
                    end
                end else if ((page >= PAGE_BASIC_FIRST) && (page <= PAGE_BASIC_LAST)) begin
                    res.read_data = (lo && hi) ? rom_img[addr] : ram_img[addr];
                end else if (page >= PAGE_KERNAL_FIRST) begin
                    res.read_data = hi ? rom_img[addr] : ram_img[addr];
                end else begin
                    res.read_data = ram_img[addr];
                end
            end
            bmm_pkg::OP_CPU_WRITE: begin
                if (addr == bmm_pkg::LAYOUT_ADDR) begin
                    layout        = data[2:0];
                    ram_img[addr] = data;
                end else if (video_page && (area == CHR_AREA_IO)) begin
                    res.dev_sel = bmm_pkg::DEV_VIDEO;
                    res.dev_reg = addr[6:0];
                    res.dev_wr  = 1'b1;
                end else if (io_page && (area == CHR_AREA_IO)) begin
                    res.dev_sel = (page == PAGE_IO1) ? bmm_pkg::DEV_IO1 : bmm_pkg::DEV_IO2;
                    res.dev_reg = {3'b000, addr[3:0]};
                    res.dev_wr  = 1'b1;
                end else begin
                    // writes under rom or into a non-i/o area land in ram
                    ram_img[addr] = data;
                end
            end
            bmm_pkg::OP_RAW_READ: res.read_data = ram_img[addr];
            bmm_pkg::OP_RAW_WRITE: ram_img[addr] = data;
            bmm_pkg::OP_VID_READ: begin
                va = {bank, addr[13:0]};
                if ((va[15:12] == CHR_WINDOW_LOW) || (va[15:12] == CHR_WINDOW_HIGH))
                    res.read_data = rom_img[{bmm_pkg::CHAR_ROM_HI, va[11:0]}];
                else
                    res.read_data = ram_img[va];
            end
            bmm_pkg::OP_ROM_LOAD: rom_img[addr] = data;
            default: ;
        endcase
        return res;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : monitor
        t_bus_result want;
        t_bus_result got;

        if (!i_rst_n) begin
            for (int a = 0; a < bmm_pkg::MEM_DEPTH; a++) begin
                ram_img[a] = 8'h00;
                rom_img[a] = 8'h00;
            end
            ram_img[bmm_pkg::PORT_DIR_ADDR] = bmm_pkg::PORT_DIR_INIT;
            ram_img[bmm_pkg::LAYOUT_ADDR]   = bmm_pkg::LAYOUT_INIT;
            layout                          = bmm_pkg::LAYOUT_RESET;
            expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(map_access(i_op, i_address, i_data, i_video_bank));
            if (i_out_valid && !i_out_stall) begin
                got = {i_read_data, i_device_select, i_device_register, i_device_write};
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result data %02h select %0d reg %02h write %0b",
                                 $realtime, got.read_data, got.dev_sel, got.dev_reg, got.dev_wr);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("%0t: mismatch exp %02h/%0d/%02h/%0b got %02h/%0d/%02h/%0b",
                                     $realtime, want.read_data, want.dev_sel, want.dev_reg,
                                     want.dev_wr, got.read_data, got.dev_sel, got.dev_reg,
                                     got.dev_wr);
                    end
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

[test/tb_banked_memory_mapper_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_banked_memory_mapper_unit
// Drives directed and random memory transactions into the mapper under
// several sender and receiver idling mixes; the checker beside the block
// predicts every result and this top reports the verdict.
// ---------------------------------------------------------------------------
module tb_banked_memory_mapper_unit;

    localparam int         RESET_CYCLES = 11;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         DRAIN_CYCLES = 10;
    // covers the clearing pass plus a wide margin for stalls and gaps
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [2:0] OP_SPARE_6   = 3'd6;
    localparam logic [2:0] OP_SPARE_7   = 3'd7;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [2:0]  i_op         = bmm_pkg::OP_CPU_READ;
    logic [15:0] i_address    = '0;
    logic [7:0]  i_data       = '0;
    logic [1:0]  i_video_bank = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [1:0]  o_device_select;
    logic [6:0]  o_device_register;
    logic        o_device_write;

    int gap_pct     = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int mismatches;
    int pending;

    banked_memory_mapper_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_address         (i_address),
        .i_data            (i_data),
        .i_video_bank      (i_video_bank),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_device_select   (o_device_select),
        .o_device_register (o_device_register),
        .o_device_write    (o_device_write)
    );

    bmm_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_op              (i_op),
        .i_address         (i_address),
        .i_data            (i_data),
        .i_video_bank      (i_video_bank),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_read_data       (o_read_data),
        .i_device_select   (o_device_select),
        .i_device_register (o_device_register),
        .i_device_write    (o_device_write),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    always #2 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(1, 100) <= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // present one transaction, with random idle cycles ahead of it
    task automatic issue(input logic [2:0] op, input logic [15:0] addr,
                         input logic [7:0] data, input logic [1:0] bank);
        while ((gap_pct > 0) && ($urandom_range(1, 100) <= gap_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_address    <= addr;
        i_data       <= data;
        i_video_bank <= bank;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // addresses clustered on region edges so reads find earlier writes
    function automatic logic [15:0] pick_address();
        logic [15:0] base;

        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 16'hffff));
        case ($urandom_range(0, 13))
            0:  base = 16'h0000;
            1:  base = 16'h1000;
            2:  base = 16'h5000;
            3:  base = 16'h9000;
            4:  base = 16'ha000;
            5:  base = 16'hbff0;
            6:  base = 16'hd000;
            7:  base = 16'hd3f0;
            8:  base = 16'hd800;
            9:  base = 16'hdc00;
            10: base = 16'hdd00;
            11: base = 16'hde00;
            12: base = 16'he000;
            default: base = 16'hfff0;
        endcase
        return base + 16'($urandom_range(0, 15));
    endfunction

    // one random transaction, mostly well-formed accesses
    task automatic random_item();
        logic [2:0]  op;
        logic [15:0] addr;
        int          pick;

        pick = $urandom_range(0, 99);
        addr = pick_address();
        if (pick < 6) begin
            op   = bmm_pkg::OP_CPU_WRITE;
            addr = bmm_pkg::LAYOUT_ADDR;
        end else if (pick < 30) op = bmm_pkg::OP_CPU_READ;
        else if (pick < 48) op = bmm_pkg::OP_CPU_WRITE;
        else if (pick < 58) op = bmm_pkg::OP_RAW_READ;
        else if (pick < 66) op = bmm_pkg::OP_RAW_WRITE;
        else if (pick < 80) op = bmm_pkg::OP_VID_READ;
        else if (pick < 94) op = bmm_pkg::OP_ROM_LOAD;
        else if (pick < 97) op = OP_SPARE_6;
        else op = OP_SPARE_7;
        issue(op, addr, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rom contents, the rom and device areas under the reset layout
        issue(bmm_pkg::OP_ROM_LOAD,  16'hffff, 8'ha5, 2'd0);
        issue(bmm_pkg::OP_ROM_LOAD,  16'he000, 8'h5a, 2'd1);
        issue(bmm_pkg::OP_ROM_LOAD,  16'ha000, 8'hc3, 2'd2);
        issue(bmm_pkg::OP_ROM_LOAD,  16'hd000, 8'h3c, 2'd3);
        issue(bmm_pkg::OP_ROM_LOAD,  16'hdfff, 8'h81, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hffff, 8'hff, 2'd3);
        issue(bmm_pkg::OP_CPU_READ,  16'ha000, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hd000, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hd3ff, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hdc0f, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_WRITE, 16'hddff, 8'hff, 2'd0);
        // write under rom, then read it back raw
        issue(bmm_pkg::OP_CPU_WRITE, 16'he000, 8'h99, 2'd0);
        issue(bmm_pkg::OP_RAW_READ,  16'he000, 8'h00, 2'd0);
        // character rom windows and the top of the last bank
        issue(bmm_pkg::OP_VID_READ,  16'h1000, 8'h00, 2'd0);
        issue(bmm_pkg::OP_VID_READ,  16'h1fff, 8'h00, 2'd2);
        issue(bmm_pkg::OP_VID_READ,  16'hffff, 8'h00, 2'd3);
        // raw write to the layout byte leaves the layout alone
        issue(bmm_pkg::OP_RAW_WRITE, bmm_pkg::LAYOUT_ADDR, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hffff, 8'h00, 2'd0);
        // all layout bits clear: char area shows rom, kernal shows ram
        issue(bmm_pkg::OP_CPU_WRITE, bmm_pkg::LAYOUT_ADDR, 8'hf8, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hd000, 8'h00, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'he000, 8'h00, 2'd0);
        // only charen set: char area and device pages show ram
        issue(bmm_pkg::OP_CPU_WRITE, bmm_pkg::LAYOUT_ADDR, 8'h04, 2'd0);
        issue(bmm_pkg::OP_CPU_READ,  16'hdc00, 8'h00, 2'd0);
        issue(OP_SPARE_6,            16'h0000, 8'h55, 2'd1);
        issue(OP_SPARE_7,            16'hffff, 8'haa, 2'd2);
        issue(bmm_pkg::OP_CPU_WRITE, bmm_pkg::LAYOUT_ADDR, 8'h07, 2'd0);

        // random phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                random_item();
        end

        // drain
        i_valid   <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if ((mismatches == 0) && (pending == 0))
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
